[sv/cprf_pkg.sv]
package cprf_pkg;

    localparam int POS_WIDTH = 32;
    localparam int COORD_W   = 31;
    localparam int REF_W     = 33;
    localparam int LEN_W     = 32;
    localparam int CIG_W     = 28;
    localparam int FLAG_W    = 16;
    localparam int MAPQ_W    = 8;
    localparam int QW        = (POS_WIDTH > COORD_W) ? POS_WIDTH : COORD_W;
    localparam int SW        = QW + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [FLAG_W-1:0] FLAG_PAIRED   = 16'h0001;
    localparam logic [FLAG_W-1:0] FLAG_PROPER   = 16'h0002;
    localparam logic [FLAG_W-1:0] FLAG_UNMAPPED = 16'h0004;

    typedef enum logic [3:0] {
        OP_M  = 4'd0,
        OP_I  = 4'd1,
        OP_D  = 4'd2,
        OP_N  = 4'd3,
        OP_S  = 4'd4,
        OP_H  = 4'd5,
        OP_P  = 4'd6,
        OP_EQ = 4'd7,
        OP_X  = 4'd8
    } t_cigar_op;

    typedef enum logic [2:0] {
        V_PASS    = 3'd0,
        V_TAG     = 3'd1,
        V_HEADER  = 3'd2,
        V_DEL     = 3'd3,
        V_SKIP    = 3'd4,
        V_SHORT   = 3'd5,
        V_UNCOVER = 3'd6
    } t_verdict;

    typedef enum logic [1:0] {
        HIT_MATCH = 2'd0,
        HIT_DEL   = 2'd1,
        HIT_SKIP  = 2'd2
    } t_hit_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEED_UMI     = 3'd0,
        CFG_NEED_CELL    = 3'd1,
        CFG_MAPQ_FLOOR   = 3'd2,
        CFG_REJECT_MASK  = 3'd3,
        CFG_REQUIRE_MASK = 3'd4,
        CFG_DROP_ORPHANS = 3'd5,
        CFG_MIN_ALEN     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic                first_op;
        logic                last_op;
        logic [COORD_W-1:0]  target_pos;
        logic [COORD_W-1:0]  read_start;
        logic                ref_id_valid;
        logic [FLAG_W-1:0]   read_flag;
        logic [MAPQ_W-1:0]   map_quality;
        logic                umi_present;
        logic                cell_tag_present;
        logic [3:0]          cigar_op;
        logic [CIG_W-1:0]    cigar_len;
    } t_item;

endpackage

[sv/cigar_pos_resolve_filter.sv]
// CIGAR position resolver and read filter. One CIGAR operation of an aligned read is taken
// per transaction, one transaction per clock when neither side stalls. Each operation goes
// into an input register and, when the output is not stalled, updates the running reference
// and query coordinates and the aligned base count; that accumulator update
// is the loop that sets the rate of one operation per clock. The operation marked last_op
// yields one result in the result register, which is loaded from the input register and
// holds the verdict, the query offset of the target base and the saturating aligned
// length. Operations without last_op give no result. The configuration port is always
// ready and should only be written while no read is in flight.
module cigar_pos_resolve_filter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_first_op,
    input  logic                               i_last_op,
    input  logic [cprf_pkg::COORD_W-1:0]       i_target_pos,
    input  logic [cprf_pkg::COORD_W-1:0]       i_read_start,
    input  logic                               i_ref_id_valid,
    input  logic [cprf_pkg::FLAG_W-1:0]        i_read_flag,
    input  logic [cprf_pkg::MAPQ_W-1:0]        i_map_quality,
    input  logic                               i_umi_present,
    input  logic                               i_cell_tag_present,
    input  logic [3:0]                         i_cigar_op,
    input  logic [cprf_pkg::CIG_W-1:0]         i_cigar_len,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_verdict,
    output logic [cprf_pkg::COORD_W-1:0]       o_query_offset,
    output logic [cprf_pkg::LEN_W-1:0]         o_aligned_length,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cprf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cprf_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    // configuration
    logic                            r_need_umi;
    logic                            r_need_cell;
    logic [cprf_pkg::MAPQ_W-1:0]     r_mapq_floor;
    logic [cprf_pkg::FLAG_W-1:0]     r_reject_mask;
    logic [cprf_pkg::FLAG_W-1:0]     r_require_mask;
    logic                            r_drop_orphans;
    logic [cprf_pkg::LEN_W-1:0]      r_min_alen;

    // input stage
    logic                            r_in_valid;
    cprf_pkg::t_item                 r_in;

    // accumulators
    logic [cprf_pkg::REF_W-1:0]      r_ref, n_ref;
    logic [cprf_pkg::POS_WIDTH-1:0]  r_q, n_q;
    logic [cprf_pkg::LEN_W-1:0]      r_m, n_m;
    logic                            r_found, n_found;
    cprf_pkg::t_hit_kind             r_kind, n_kind;
    logic [cprf_pkg::POS_WIDTH-1:0]  r_hoff, n_hoff;

    // result register
    logic                            r_out_valid;
    cprf_pkg::t_verdict              r_verdict, n_verdict;
    logic [cprf_pkg::COORD_W-1:0]    r_qoff, n_qoff;
    logic [cprf_pkg::LEN_W-1:0]      r_alen, n_alen;

    logic                            adv;
    logic                            exec;

    logic                            aligned, refonly, qonly;
    logic [cprf_pkg::REF_W-1:0]      base_ref;
    logic [cprf_pkg::POS_WIDTH-1:0]  base_q;
    logic [cprf_pkg::LEN_W-1:0]      base_m;
    logic                            base_found;
    cprf_pkg::t_hit_kind             base_kind;
    logic [cprf_pkg::POS_WIDTH-1:0]  base_hoff;
    logic [cprf_pkg::REF_W:0]        ref_sum;
    logic [cprf_pkg::REF_W-1:0]      ref_adv;
    logic [cprf_pkg::SW-1:0]         q_sum;
    logic [cprf_pkg::POS_WIDTH-1:0]  q_adv;
    logic [cprf_pkg::LEN_W:0]        m_sum;
    logic [cprf_pkg::COORD_W-1:0]    diff;
    logic [cprf_pkg::SW-1:0]         h_sum;
    logic [cprf_pkg::POS_WIDTH-1:0]  h_sat;
    logic [cprf_pkg::REF_W-1:0]      tgt_ext;
    logic [cprf_pkg::QW-1:0]         hoff_ext;
    logic                            tag_miss;
    logic                            hdr_bad;

    assign adv         = !r_out_valid || !i_out_stall;
    assign exec        = r_in_valid && adv;
    assign o_in_stall  = r_in_valid && !adv;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_query_offset   = r_qoff;
    assign o_aligned_length = r_alen;

    always_comb begin
        aligned = 1'b0;
        refonly = 1'b0;
        qonly   = 1'b0;
        unique case (cprf_pkg::t_cigar_op'(r_in.cigar_op)) inside
            cprf_pkg::OP_M, cprf_pkg::OP_EQ, cprf_pkg::OP_X: aligned = 1'b1;
            cprf_pkg::OP_D, cprf_pkg::OP_N:                  refonly = 1'b1;
            cprf_pkg::OP_I, cprf_pkg::OP_S:                  qonly   = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        base_ref   = r_in.first_op ? cprf_pkg::REF_W'(r_in.read_start) : r_ref;
        base_q     = r_in.first_op ? '0 : r_q;
        base_m     = r_in.first_op ? '0 : r_m;
        base_found = r_in.first_op ? 1'b0 : r_found;
        base_kind  = r_in.first_op ? cprf_pkg::HIT_MATCH : r_kind;
        base_hoff  = r_in.first_op ? '0 : r_hoff;

        ref_sum = {1'b0, base_ref} + (cprf_pkg::REF_W + 1)'(r_in.cigar_len);
        ref_adv = ref_sum[cprf_pkg::REF_W] ? '1 : ref_sum[cprf_pkg::REF_W-1:0];

        q_sum = cprf_pkg::SW'(base_q) + cprf_pkg::SW'(r_in.cigar_len);
        q_adv = (|q_sum[cprf_pkg::SW-1:cprf_pkg::POS_WIDTH]) ? '1
                : q_sum[cprf_pkg::POS_WIDTH-1:0];

        m_sum = {1'b0, base_m} + (cprf_pkg::LEN_W + 1)'(r_in.cigar_len);

        tgt_ext = cprf_pkg::REF_W'(r_in.target_pos);
        diff    = r_in.target_pos - base_ref[cprf_pkg::COORD_W-1:0];
        h_sum   = cprf_pkg::SW'(base_q) + cprf_pkg::SW'(diff);
        h_sat   = (|h_sum[cprf_pkg::SW-1:cprf_pkg::POS_WIDTH]) ? '1
                  : h_sum[cprf_pkg::POS_WIDTH-1:0];

        n_m = base_m;
        if (aligned) begin
            n_m = m_sum[cprf_pkg::LEN_W] ? '1 : m_sum[cprf_pkg::LEN_W-1:0];
        end

        n_ref   = base_ref;
        n_q     = base_q;
        n_found = base_found;
        n_kind  = base_kind;
        n_hoff  = base_hoff;
        if (!base_found) begin
            if (aligned || refonly) begin
                n_ref = ref_adv;
            end
            if (aligned || qonly) begin
                n_q = q_adv;
            end
            if ((aligned || refonly) && base_ref <= tgt_ext && ref_adv > tgt_ext) begin
                n_found = 1'b1;
                if (aligned) begin
                    n_kind = cprf_pkg::HIT_MATCH;
                    n_hoff = h_sat;
                end else begin
                    n_kind = (cprf_pkg::t_cigar_op'(r_in.cigar_op) == cprf_pkg::OP_D)
                             ? cprf_pkg::HIT_DEL : cprf_pkg::HIT_SKIP;
                    n_hoff = base_q;
                end
            end
        end
    end

    always_comb begin
        tag_miss = (r_need_umi && !r_in.umi_present)
                || (r_need_cell && !r_in.cell_tag_present);
        hdr_bad  = !r_in.ref_id_valid
                || (|(r_in.read_flag & cprf_pkg::FLAG_UNMAPPED))
                || (r_in.map_quality < r_mapq_floor)
                || (|(r_reject_mask & r_in.read_flag))
                || ((|r_require_mask) && !(|(r_require_mask & r_in.read_flag)))
                || (r_drop_orphans && (|(r_in.read_flag & cprf_pkg::FLAG_PAIRED))
                    && !(|(r_in.read_flag & cprf_pkg::FLAG_PROPER)));
        hoff_ext = cprf_pkg::QW'(n_hoff);

        n_qoff = '0;
        n_alen = '0;
        if (tag_miss) begin
            n_verdict = cprf_pkg::V_TAG;
        end else if (hdr_bad) begin
            n_verdict = cprf_pkg::V_HEADER;
        end else if (!n_found) begin
            n_verdict = cprf_pkg::V_UNCOVER;
        end else begin
            n_qoff = (hoff_ext > cprf_pkg::QW'({cprf_pkg::COORD_W{1'b1}})) ? '1
                     : hoff_ext[cprf_pkg::COORD_W-1:0];
            if (n_kind == cprf_pkg::HIT_DEL) begin
                n_verdict = cprf_pkg::V_DEL;
            end else if (n_kind == cprf_pkg::HIT_SKIP) begin
                n_verdict = cprf_pkg::V_SKIP;
            end else begin
                n_verdict = (n_m < r_min_alen) ? cprf_pkg::V_SHORT : cprf_pkg::V_PASS;
                n_alen    = n_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_umi     <= 1'b0;
            r_need_cell    <= 1'b0;
            r_mapq_floor   <= '0;
            r_reject_mask  <= '0;
            r_require_mask <= '0;
            r_drop_orphans <= 1'b0;
            r_min_alen     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (cprf_pkg::t_cfg_idx'(i_cfg_index))
                cprf_pkg::CFG_NEED_UMI:     r_need_umi     <= i_cfg_data[0];
                cprf_pkg::CFG_NEED_CELL:    r_need_cell    <= i_cfg_data[0];
                cprf_pkg::CFG_MAPQ_FLOOR:   r_mapq_floor   <= i_cfg_data[cprf_pkg::MAPQ_W-1:0];
                cprf_pkg::CFG_REJECT_MASK:  r_reject_mask  <= i_cfg_data[cprf_pkg::FLAG_W-1:0];
                cprf_pkg::CFG_REQUIRE_MASK: r_require_mask <= i_cfg_data[cprf_pkg::FLAG_W-1:0];
                cprf_pkg::CFG_DROP_ORPHANS: r_drop_orphans <= i_cfg_data[0];
                cprf_pkg::CFG_MIN_ALEN:     r_min_alen     <= i_cfg_data[cprf_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.first_op         <= i_first_op;
            r_in.last_op          <= i_last_op;
            r_in.target_pos       <= i_target_pos;
            r_in.read_start       <= i_read_start;
            r_in.ref_id_valid     <= i_ref_id_valid;
            r_in.read_flag        <= i_read_flag;
            r_in.map_quality      <= i_map_quality;
            r_in.umi_present      <= i_umi_present;
            r_in.cell_tag_present <= i_cell_tag_present;
            r_in.cigar_op         <= i_cigar_op;
            r_in.cigar_len        <= i_cigar_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= '0;
            r_q     <= '0;
            r_m     <= '0;
            r_found <= 1'b0;
            r_kind  <= cprf_pkg::HIT_MATCH;
            r_hoff  <= '0;
        end else if (exec) begin
            r_ref   <= n_ref;
            r_q     <= n_q;
            r_m     <= n_m;
            r_found <= n_found;
            r_kind  <= n_kind;
            r_hoff  <= n_hoff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && r_in.last_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && r_in.last_op) begin
            r_verdict <= n_verdict;
            r_qoff    <= n_qoff;
            r_alen    <= n_alen;
        end
    end

`ifndef SYNTHESIS
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(exec && r_in.last_op))
        else $error("result appeared without a last operation");

    a_found_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_found) |-> ($past(exec && r_in.first_op) || !$past(i_rst_n)))
        else $error("target hit dropped outside a first operation");

    a_qoff_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_verdict == cprf_pkg::V_TAG || r_verdict == cprf_pkg::V_HEADER
                         || r_verdict == cprf_pkg::V_UNCOVER)) |-> (r_qoff == '0))
        else $error("query offset set on a rejected read");

    a_alen_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict != cprf_pkg::V_PASS && r_verdict != cprf_pkg::V_SHORT)
        |-> (r_alen == '0))
        else $error("aligned length set for a non-match verdict");
`endif

endmodule
